// ===== hdl/mqufi_pkg.sv =====
// Package for the queue bank: field widths, request kinds, shift commands, result codes and the sequencer state type.
`default_nettype none

package mqufi_pkg;

  // Width of the queue select field on the request channel
  localparam int unsigned SEL_W     = 4;
  // Widths of the result fields
  localparam int unsigned OUT_ID_W  = 16;
  localparam int unsigned OUT_LEN_W = 4;

  // Request kinds
  localparam logic REQ_ADD  = 1'b0;
  localparam logic REQ_TAKE = 1'b1;

  // Result codes
  typedef enum logic [1:0] {
    OUT_ADDED = 2'd0,
    OUT_FULL  = 2'd1,
    OUT_TAKEN = 2'd2,
    OUT_EMPTY = 2'd3
  } outcome_t;

  // Command broadcast along the row of slot cells
  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_APPEND     = 2'd1,
    CMD_PUSH_FRONT = 2'd2,
    CMD_POP        = 2'd3
  } cell_cmd_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

endpackage

`default_nettype wire

// ===== hdl/mqufi_cell.sv =====
// One slot position of every queue: a small memory indexed by queue, shifting with its neighbors.
`default_nettype none

module mqufi_cell
  import mqufi_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned ID_WIDTH    = 16,
  parameter int unsigned POS         = 0
) (
  input  wire logic                                           clk,
  input  wire logic                                           rd_en,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] rd_addr,
  input  wire logic [((NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1)-1:0] wr_addr,
  input  wire cell_cmd_t                                      cmd,
  input  wire logic [$clog2(QUEUE_DEPTH + 1)-1:0]             len,
  input  wire logic [ID_WIDTH:0]                              new_entry,
  input  wire logic [ID_WIDTH:0]                              prev_entry,
  input  wire logic [ID_WIDTH:0]                              next_entry,
  output logic      [ID_WIDTH:0]                              entry
);

  localparam int unsigned EW = ID_WIDTH + 1;

  logic [EW-1:0] mem [NUM_QUEUES];
  logic          wr_en;
  logic [EW-1:0] wr_data;

  // Pick this position's move for the broadcast command
  always_comb begin
    wr_en   = 1'b0;
    wr_data = new_entry;
    case (cmd)
      CMD_APPEND: begin
        wr_en   = (POS == int'(len));
        wr_data = new_entry;
      end
      CMD_PUSH_FRONT: begin
        if (POS == 0) begin
          wr_en   = 1'b1;
          wr_data = new_entry;
        end else begin
          wr_en   = (POS <= int'(len));
          wr_data = prev_entry;
        end
      end
      CMD_POP: begin
        wr_en   = ((POS + 1) < int'(len));
        wr_data = next_entry;
      end
      default: begin
        wr_en   = 1'b0;
        wr_data = new_entry;
      end
    endcase
  end

  // Write the shifted or new entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the addressed queue's slot on request accept
  always_ff @(posedge clk) begin
    if (rd_en) begin
      entry <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// ===== hdl/multi_queue_urgent_front_insert_unit.sv =====
// Top level of the queue bank: request sequencer, queue counts and the row of slot cells.
//
//  channel   | handshake               | fields
//  ----------+-------------------------+--------------------------------------------------
//  request   | in_valid / in_ready     | req_type, queue_sel, entry_id, urgent
//  result    | out_valid / out_ready   | outcome, taken_id, taken_urgent, queue_length
//
// Each item is handled in steps: the selected queue's slot row and count are read on accept,
// then the execute step shifts the cells, updates the count and loads the result register.
// The result register frees the request side; a new item is taken while a result waits.
// A stalled result holds the execute step until the output register is free.
// rst is synchronous, active high, and clears the counts' valid bits and control state.
`default_nettype none

module multi_queue_urgent_front_insert_unit
  import mqufi_pkg::*;
#(
  parameter int unsigned NUM_QUEUES  = 16,
  parameter int unsigned QUEUE_DEPTH = 8,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 req_type,
  input  wire logic [SEL_W-1:0]     queue_sel,
  input  wire logic [15:0]          entry_id,
  input  wire logic                 urgent,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [1:0]                outcome,
  output logic [OUT_ID_W-1:0]       taken_id,
  output logic                      taken_urgent,
  output logic [OUT_LEN_W-1:0]      queue_length
);

  localparam int unsigned AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = ID_WIDTH + 1;

  state_t state, state_next;

  // Latched request
  logic                req_take;
  logic                req_urg;
  logic [ID_WIDTH-1:0] req_id;
  logic [AW-1:0]       req_addr;
  logic                req_in_range;

  // Queue counts: memory plus valid bits
  logic [CW-1:0]       cnt_mem [NUM_QUEUES];
  logic [CW-1:0]       cnt_rd;
  logic [NUM_QUEUES-1:0] cnt_valid;

  logic                in_acc;
  logic                advance;
  logic [AW-1:0]       in_addr;
  logic                in_range;
  logic [SEL_W+AW-1:0] sel_wide;
  logic [15+ID_WIDTH:0] id_wide;

  logic [CW-1:0]       len;
  logic [CW-1:0]       len_new;
  logic                cnt_we;
  cell_cmd_t           cmd;
  outcome_t            res_code;
  logic [ID_WIDTH-1:0] res_id;
  logic                res_urg;
  logic [OUT_ID_W+ID_WIDTH-1:0] res_id_wide;
  logic [OUT_LEN_W+CW-1:0]      len_wide;

  logic [EW-1:0]       row [QUEUE_DEPTH];
  logic [EW-1:0]       new_entry;

  // Decode the request fields
  assign sel_wide = {{AW{1'b0}}, queue_sel};
  assign in_addr  = sel_wide[AW-1:0];
  assign in_range = (int'(queue_sel) < NUM_QUEUES);
  assign id_wide  = {{ID_WIDTH{1'b0}}, entry_id};

  assign in_acc  = in_valid && in_ready;
  assign advance = (state == ST_EXEC) && (!out_valid || out_ready);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (advance) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready = 1'b0;
    case (state)
      ST_IDLE: in_ready = !rst;
      ST_EXEC: in_ready = 1'b0;
      default: in_ready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Hold the request while the cells work on it
  always_ff @(posedge clk) begin
    if (in_acc) begin
      req_take     <= req_type;
      req_urg      <= urgent;
      req_id       <= id_wide[ID_WIDTH-1:0];
      req_addr     <= in_addr;
      req_in_range <= in_range;
    end
  end

  // Read the selected queue's count
  always_ff @(posedge clk) begin
    if (in_acc) begin
      cnt_rd <= cnt_mem[in_addr];
    end
  end

  // Decide the result and the shift command
  always_comb begin
    len      = (req_in_range && cnt_valid[req_addr]) ? cnt_rd : '0;
    len_new  = len;
    cnt_we   = 1'b0;
    cmd      = CMD_NONE;
    res_code = OUT_FULL;
    res_id   = '0;
    res_urg  = 1'b0;
    if (!req_in_range) begin
      res_code = (req_take == REQ_TAKE) ? OUT_EMPTY : OUT_FULL;
      len_new  = '0;
    end else if (req_take == REQ_ADD) begin
      if (len == CW'(QUEUE_DEPTH)) begin
        res_code = OUT_FULL;
      end else begin
        res_code = OUT_ADDED;
        cmd      = (req_urg && (len != '0)) ? CMD_PUSH_FRONT : CMD_APPEND;
        len_new  = CW'(len + 1'b1);
        cnt_we   = 1'b1;
      end
    end else begin
      if (len == '0) begin
        res_code = OUT_EMPTY;
      end else begin
        res_code = OUT_TAKEN;
        cmd      = CMD_POP;
        res_id   = row[0][ID_WIDTH-1:0];
        res_urg  = row[0][ID_WIDTH];
        len_new  = CW'(len - 1'b1);
        cnt_we   = 1'b1;
      end
    end
  end

  // Update the count
  always_ff @(posedge clk) begin
    if (advance && cnt_we) begin
      cnt_mem[req_addr] <= len_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_valid <= '0;
    end else if (advance && cnt_we) begin
      cnt_valid[req_addr] <= 1'b1;
    end
  end

  // Row of slot cells, each fed by its neighbors
  assign new_entry = {req_urg, req_id};

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [EW-1:0] prev_e;
    logic [EW-1:0] next_e;

    if (k == 0) begin : g_first
      assign prev_e = '0;
    end else begin : g_mid_prev
      assign prev_e = row[k-1];
    end

    if (k == QUEUE_DEPTH - 1) begin : g_last
      assign next_e = '0;
    end else begin : g_mid_next
      assign next_e = row[k+1];
    end

    mqufi_cell #(
      .NUM_QUEUES  (NUM_QUEUES),
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .ID_WIDTH    (ID_WIDTH),
      .POS         (k)
    ) u_cell (
      .clk        (clk),
      .rd_en      (in_acc),
      .rd_addr    (in_addr),
      .wr_addr    (req_addr),
      .cmd        (advance ? cmd : CMD_NONE),
      .len        (len),
      .new_entry  (new_entry),
      .prev_entry (prev_e),
      .next_entry (next_e),
      .entry      (row[k])
    );
  end

  // Load the result register
  assign res_id_wide = {{OUT_ID_W{1'b0}}, res_id};
  assign len_wide    = {{OUT_LEN_W{1'b0}}, len_new};

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      outcome      <= res_code;
      taken_id     <= res_id_wide[OUT_ID_W-1:0];
      taken_urgent <= res_urg;
      queue_length <= len_wide[OUT_LEN_W-1:0];
    end
  end

`ifndef SYNTHESIS
  a_accept_starts_exec: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == ST_EXEC)
    else $error("accepted item did not enter execute");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_EXEC)
    else $error("result appeared without an executed item");

  a_count_bounded: assert property (@(posedge clk) disable iff (rst)
    state == ST_EXEC && req_in_range && cnt_valid[req_addr] |-> cnt_rd <= CW'(QUEUE_DEPTH))
    else $error("queue count above depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    advance && cmd == CMD_POP |-> len != '0)
    else $error("pop issued on an empty queue");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_multi_queue_urgent_front_insert_unit.sv =====
// Self-checking testbench for the queue bank with urgent insertion at the head.
module tb_multi_queue_urgent_front_insert_unit;
  import mqufi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NQ          = 16;
  localparam int unsigned QD          = 8;
  localparam int unsigned IDW         = 16;
  localparam logic [15:0] ID_MASK     = 16'((64'd1 << IDW) - 64'd1);
  localparam time         PERIOD      = 10ns;
  localparam int unsigned CYCLE_LIMIT = 200_000;

  // One result of the block, as predicted
  typedef struct packed {
    outcome_t    outcome;
    logic [15:0] taken_id;
    logic        taken_urgent;
    logic [3:0]  queue_length;
  } queue_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        req_type = REQ_ADD;
  logic [3:0]  queue_sel = '0;
  logic [15:0] entry_id = '0;
  logic        urgent = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  outcome;
  logic [15:0] taken_id;
  logic        taken_urgent;
  logic [3:0]  queue_length;

  // Shadow copy of the queue bank; entry 0 of each row is the head
  logic [15:0] shadow_id  [NQ][QD];
  logic        shadow_urg [NQ][QD];
  int unsigned shadow_len [NQ] = '{default: 0};

  queue_result_t pending_results[$];
  int unsigned   mismatch_count = 0;
  int unsigned   items_accepted = 0;
  int unsigned   outcome_tally [4] = '{default: 0};
  int unsigned   cycle_count = 0;

  // Receiver pacing state
  int unsigned hold_off_left = 0;
  int unsigned rx_stall_left = 0;
  int unsigned rx_free_left  = 0;
  // Sender pacing state
  int unsigned tx_burst_left = 0;

  multi_queue_urgent_front_insert_unit #(
    .NUM_QUEUES (NQ),
    .QUEUE_DEPTH(QD),
    .ID_WIDTH   (IDW)
  ) i_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .req_type    (req_type),
    .queue_sel   (queue_sel),
    .entry_id    (entry_id),
    .urgent      (urgent),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .outcome     (outcome),
    .taken_id    (taken_id),
    .taken_urgent(taken_urgent),
    .queue_length(queue_length)
  );

  always #(PERIOD / 2) clk = ~clk;

  // Apply one request to the shadow bank and return the result it causes
  function automatic queue_result_t queue_bank_step(logic kind, logic [3:0] sel,
                                                    logic [15:0] id, logic urg);
    queue_result_t res;
    int unsigned   q;
    int unsigned   len;
    res = '0;
    if (sel >= NQ) begin
      res.outcome = (kind == REQ_TAKE) ? OUT_EMPTY : OUT_FULL;
      return res;
    end
    q   = sel;
    len = shadow_len[q];
    if (kind == REQ_ADD) begin
      if (len >= QD) begin
        res.outcome      = OUT_FULL;
        res.queue_length = 4'(len);
        return res;
      end
      if (urg) begin
        // urgent entry goes in front of everything, newest urgent first
        for (int i = len; i > 0; i--) begin
          shadow_id[q][i]  = shadow_id[q][i-1];
          shadow_urg[q][i] = shadow_urg[q][i-1];
        end
        shadow_id[q][0]  = id & ID_MASK;
        shadow_urg[q][0] = 1'b1;
      end else begin
        shadow_id[q][len]  = id & ID_MASK;
        shadow_urg[q][len] = 1'b0;
      end
      shadow_len[q]    = len + 1;
      res.outcome      = OUT_ADDED;
      res.queue_length = 4'(len + 1);
    end else if (len == 0) begin
      res.outcome = OUT_EMPTY;
    end else begin
      res.outcome      = OUT_TAKEN;
      res.taken_id     = shadow_id[q][0];
      res.taken_urgent = shadow_urg[q][0];
      for (int i = 0; i + 1 < len; i++) begin
        shadow_id[q][i]  = shadow_id[q][i+1];
        shadow_urg[q][i] = shadow_urg[q][i+1];
      end
      shadow_len[q]    = len - 1;
      res.queue_length = 4'(len - 1);
    end
    return res;
  endfunction

  function automatic void compare_field(string field, int unsigned want, int unsigned got);
    if (want != got) begin
      mismatch_count++;
      $display("%0t: mismatch in %s: expected %0d (0x%0h), actual %0d (0x%0h)",
               $time, field, want, want, got, got);
    end
  endfunction

  // Predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        pending_results.push_back(queue_bank_step(req_type, queue_sel, entry_id, urgent));
        items_accepted++;
      end
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          mismatch_count++;
          $display("%0t: unexpected result: expected none, actual outcome %0d id 0x%0h",
                   $time, outcome, taken_id);
        end else begin
          want = pending_results.pop_front();
          outcome_tally[want.outcome]++;
          compare_field("outcome", want.outcome, outcome);
          compare_field("taken_id", want.taken_id, taken_id);
          compare_field("taken_urgent", want.taken_urgent, taken_urgent);
          compare_field("queue_length", want.queue_length, queue_length);
        end
      end
    end
  end

  // Drive out_ready: long hold-off on request, otherwise random stalls and free runs
  always @(negedge clk) begin
    int unsigned r;
    if (hold_off_left > 0) begin
      out_ready = 1'b0;
      hold_off_left--;
    end else if (rx_stall_left > 0) begin
      out_ready = 1'b0;
      rx_stall_left--;
    end else if (rx_free_left > 0) begin
      out_ready = 1'b1;
      rx_free_left--;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 60) begin
        rx_free_left = $urandom_range(1, 25);
        out_ready    = 1'b1;
      end else if (r < 92) begin
        rx_stall_left = $urandom_range(0, 2);
        out_ready     = 1'b0;
      end else begin
        rx_stall_left = $urandom_range(8, 30);
        out_ready     = 1'b0;
      end
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding",
               $time, cycle_count, pending_results.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Offer one item and hold it until accepted
  task automatic send_request(logic kind, logic [3:0] sel, logic [15:0] id, logic urg);
    @(negedge clk);
    req_type  = kind;
    queue_sel = sel;
    entry_id  = id;
    urgent    = urg;
    in_valid  = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // Insert a random gap after an item: bursts with none, mostly short, a few long
  task automatic sender_gap();
    int unsigned r;
    int unsigned n;
    if (tx_burst_left > 0) begin
      tx_burst_left--;
      return;
    end
    r = $urandom_range(0, 99);
    if (r < 45) begin
      tx_burst_left = $urandom_range(5, 30);
      return;
    end
    n = (r < 88) ? $urandom_range(1, 3) : $urandom_range(8, 25);
    @(negedge clk);
    in_valid  = 1'b0;
    entry_id  = 16'($urandom);
    queue_sel = 4'($urandom);
    repeat (n - 1) @(negedge clk);
  endtask

  // Drop valid and hold until every expected result is back
  task automatic wait_drained();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Edges of the fields, urgent add to an empty queue, full reject, empty take
  task automatic test_directed_edges();
    send_request(REQ_TAKE, 4'd0, 16'hFFFF, 1'b1);
    send_request(REQ_ADD, 4'd0, 16'h0000, 1'b0);
    send_request(REQ_ADD, 4'd0, 16'hFFFF, 1'b1);
    send_request(REQ_ADD, 4'd15, 16'h8001, 1'b1);
    // fill one queue with a regular/urgent mix
    for (int i = 0; i < QD; i++) begin
      send_request(REQ_ADD, 4'd3, 16'h1000 + 16'(i), 1'(i % 3 != 0));
      sender_gap();
    end
    send_request(REQ_ADD, 4'd3, 16'h7FFE, 1'b1);
    send_request(REQ_ADD, 4'd3, 16'h5555, 1'b0);
    // empty it and take once more
    for (int i = 0; i <= QD; i++) begin
      send_request(REQ_TAKE, 4'd3, 16'hAAAA, 1'(i % 2));
      sender_gap();
    end
    send_request(REQ_TAKE, 4'd0, 16'h0000, 1'b0);
    send_request(REQ_TAKE, 4'd15, 16'h0000, 1'b0);
    wait_drained();
  endtask

  // Random traffic that concentrates on a few queues per phase so they fill and empty
  task automatic test_random_traffic(int unsigned count);
    logic [3:0]  hot_a;
    logic [3:0]  hot_b;
    logic [3:0]  sel;
    int unsigned add_pct;
    int unsigned phase_left;
    phase_left = 0;
    add_pct    = 50;
    hot_a      = '0;
    hot_b      = '0;
    repeat (count) begin
      if (phase_left == 0) begin
        hot_a      = 4'($urandom);
        hot_b      = 4'($urandom);
        add_pct    = $urandom_range(20, 85);
        phase_left = $urandom_range(10, 40);
      end
      phase_left--;
      if ($urandom_range(0, 9) < 8) sel = $urandom_range(0, 1) ? hot_a : hot_b;
      else sel = 4'($urandom);
      send_request(($urandom_range(0, 99) < add_pct) ? REQ_ADD : REQ_TAKE, sel,
                   16'($urandom), 1'($urandom));
      sender_gap();
    end
  endtask

  // Hold the receiver off while items keep coming, so the input side stalls
  task automatic test_output_backpressure();
    hold_off_left = 80;
    for (int i = 0; i < 30; i++)
      send_request(($urandom_range(0, 99) < 70) ? REQ_ADD : REQ_TAKE, 4'($urandom_range(5, 7)),
                   16'($urandom), 1'($urandom));
    wait_drained();
  endtask

  // Stop sending until the block is empty, then carry on
  task automatic test_drain_pause();
    test_random_traffic(20);
    wait_drained();
    test_random_traffic(20);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed_edges();
    test_random_traffic(300);
    wait_drained();
    test_output_backpressure();
    test_drain_pause();

    repeat (10) @(posedge clk);
    $display("Covered %0d items: %0d added, %0d rejected full, %0d taken, %0d empty takes.",
             items_accepted, outcome_tally[OUT_ADDED], outcome_tally[OUT_FULL],
             outcome_tally[OUT_TAKEN], outcome_tally[OUT_EMPTY]);
    $display("Included a long output hold-off with input stall and a full drain pause.");
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches, %0d results never arrived",
               mismatch_count, pending_results.size());
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
